/* sv/imcf_pkg.sv */
// Package for the ISP memory command framer: request codes, command opcodes
// and the frame type that passes from the frame builder to the serializer.
// No dependencies.
`default_nettype none

package imcf_pkg;

  typedef enum logic [2:0] {
    REQ_CONNECT   = 3'd0,
    REQ_RD_FLASH  = 3'd1,
    REQ_WR_FLASH  = 3'd2,
    REQ_FLUSH     = 3'd3,
    REQ_RD_EEPROM = 3'd4,
    REQ_WR_EEPROM = 3'd5
  } req_t;

  localparam logic [7:0] OP_LOAD_EXT  = 8'h4D;
  localparam logic [7:0] OP_RD_FLASH  = 8'h20;
  localparam logic [7:0] OP_WR_FLASH  = 8'h40;
  localparam logic [7:0] OP_FLUSH     = 8'h4C;
  localparam logic [7:0] OP_RD_EEPROM = 8'hA0;
  localparam logic [7:0] OP_WR_EEPROM = 8'hC0;
  localparam logic [7:0] EXT_NONE     = 8'hFF;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned IDX_W       = 3;

  // Up to two 4-byte commands; byte 0 goes out first.
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic                        long_f;  // 8 bytes instead of 4
    logic                        cap;     // final byte carries read data
  } frame_t;

  typedef struct packed {
    logic busy;     // bytes still waiting to enter the output register
    logic at_last;  // final byte moves to the output register this cycle
  } ser_stat_t;

endpackage

`default_nettype wire

/* sv/imcf_frame_build.sv */
// Frame builder: turns one request and the stored extended address byte
// into the command bytes to send and the next extended address byte.
// Depends on imcf_pkg.
`default_nettype none

module imcf_frame_build (
  input  wire logic [2:0]     req_type,
  input  wire logic [24:0]    mem_address,
  input  wire logic [7:0]     data_byte,
  input  wire logic [7:0]     ext_cur,
  output imcf_pkg::frame_t    frame,
  output logic                has_out,
  output logic                ext_we,
  output logic [7:0]          ext_val
);

  logic [3:0][7:0] cmd;
  logic [7:0]      ext_new;
  logic [7:0]      lowbit;
  logic            is_flash;
  logic            emit_ext;
  logic            cap;

  always_comb begin
    ext_new  = mem_address[24:17];
    lowbit   = {4'b0, mem_address[0], 3'b0};
    is_flash = 1'b0;
    has_out  = 1'b1;
    cap      = 1'b0;
    cmd      = '0;
    unique case (req_type)
      imcf_pkg::REQ_RD_FLASH: begin
        is_flash = 1'b1;
        cap      = 1'b1;
        cmd[0]   = imcf_pkg::OP_RD_FLASH | lowbit;
        cmd[1]   = mem_address[16:9];
        cmd[2]   = mem_address[8:1];
      end
      imcf_pkg::REQ_WR_FLASH: begin
        is_flash = 1'b1;
        cmd[0]   = imcf_pkg::OP_WR_FLASH | lowbit;
        cmd[1]   = mem_address[16:9];
        cmd[2]   = mem_address[8:1];
        cmd[3]   = data_byte;
      end
      imcf_pkg::REQ_FLUSH: begin
        is_flash = 1'b1;
        cmd[0]   = imcf_pkg::OP_FLUSH;
        cmd[1]   = mem_address[16:9];
        cmd[2]   = mem_address[8:1];
      end
      imcf_pkg::REQ_RD_EEPROM: begin
        cap    = 1'b1;
        cmd[0] = imcf_pkg::OP_RD_EEPROM;
        cmd[1] = mem_address[15:8];
        cmd[2] = mem_address[7:0];
      end
      imcf_pkg::REQ_WR_EEPROM: begin
        cmd[0] = imcf_pkg::OP_WR_EEPROM;
        cmd[1] = mem_address[15:8];
        cmd[2] = mem_address[7:0];
        cmd[3] = data_byte;
      end
      default: begin
        has_out = 1'b0;
      end
    endcase

    emit_ext = is_flash && (ext_new != ext_cur);

    // connect stores 0xFF, so the next flash access reloads unless it targets 0xFF
    ext_we  = emit_ext || (req_type == imcf_pkg::REQ_CONNECT);
    ext_val = emit_ext ? ext_new : imcf_pkg::EXT_NONE;

    frame.cap    = cap;
    frame.long_f = emit_ext;
    if (emit_ext) begin
      frame.bytes[0] = imcf_pkg::OP_LOAD_EXT;
      frame.bytes[1] = 8'h00;
      frame.bytes[2] = ext_new;
      frame.bytes[3] = 8'h00;
      frame.bytes[4] = cmd[0];
      frame.bytes[5] = cmd[1];
      frame.bytes[6] = cmd[2];
      frame.bytes[7] = cmd[3];
    end else begin
      frame.bytes[0] = cmd[0];
      frame.bytes[1] = cmd[1];
      frame.bytes[2] = cmd[2];
      frame.bytes[3] = cmd[3];
      frame.bytes[4] = 8'h00;
      frame.bytes[5] = 8'h00;
      frame.bytes[6] = 8'h00;
      frame.bytes[7] = 8'h00;
    end
  end

endmodule

`default_nettype wire

/* sv/imcf_serializer.sv */
// Serializer: holds one frame and moves it byte by byte into the output
// register; takes the next frame as the last byte moves out.
// Depends on imcf_pkg.
`default_nettype none

module imcf_serializer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire imcf_pkg::frame_t     frame_in,
  output imcf_pkg::ser_stat_t       stat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_cap,
  output logic                      out_last
);

  imcf_pkg::frame_t                frame_r;
  logic                            busy_r, busy_nxt;
  logic [imcf_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [7:0]                      obyte_r;
  logic                            ocap_r;
  logic                            olast_r;
  logic [imcf_pkg::IDX_W-1:0]      end_idx;
  logic                            move;
  logic                            is_end;

  assign end_idx = {frame_r.long_f, 2'b11};
  assign is_end  = (idx_r == end_idx);
  assign move    = busy_r && (!ovalid_r || out_ready);

  assign stat.busy    = busy_r;
  assign stat.at_last = move && is_end;

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r && !out_ready;
    if (move) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = idx_r + 1'b1;
      if (is_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_in;
    end
    if (move) begin
      obyte_r <= frame_r.bytes[idx_r];
      ocap_r  <= is_end && frame_r.cap;
      olast_r <= is_end;
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_cap   = ocap_r;
  assign out_last  = olast_r;

endmodule

`default_nettype wire

/* sv/isp_memory_command_framer_unit.sv */
// ISP memory command framer top level: request channel, extended address
// byte register, frame builder and byte serializer.
// Depends on imcf_pkg, imcf_frame_build and imcf_serializer.
`default_nettype none

// Each request becomes the 4-byte serial programming command for a flash
// read, flash page-buffer write, page flush, EEPROM read or EEPROM write,
// preceded by the 4-byte load-extended-address command when a flash request
// targets a different extended address byte (address bits 24:17) than the
// stored one. Bytes leave one per cycle unless out_tready stalls them, through
// a registered output; the next request is taken in the cycle its
// predecessor's final byte enters the output register.
// Connect and unused request codes produce no bytes; connect resets the
// stored byte to 0xFF. out_tuser flags the byte whose reply is read data;
// out_tlast marks a request's final byte.
module isp_memory_command_framer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [24:0] mem_address, [32:25] data_byte, rest 0
  input  wire logic [2:0]  in_tuser,   // [2:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] mosi_byte
  output logic             out_tuser,  // [0] capture_reply
  output logic             out_tlast
);

  logic [7:0]          ext_r, ext_nxt;
  imcf_pkg::frame_t    frame;
  imcf_pkg::ser_stat_t stat;
  logic                has_out;
  logic                ext_we;
  logic [7:0]          ext_val;
  logic                in_fire;

  assign in_tready = !stat.busy || stat.at_last;
  assign in_fire   = in_tvalid && in_tready;

  imcf_frame_build u_build (
    .req_type    (in_tuser),
    .mem_address (in_tdata[24:0]),
    .data_byte   (in_tdata[32:25]),
    .ext_cur     (ext_r),
    .frame       (frame),
    .has_out     (has_out),
    .ext_we      (ext_we),
    .ext_val     (ext_val)
  );

  always_comb begin
    ext_nxt = ext_r;
    if (in_fire && ext_we) begin
      ext_nxt = ext_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= imcf_pkg::EXT_NONE;
    end else begin
      ext_r <= ext_nxt;
    end
  end

  imcf_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && has_out),
    .frame_in  (frame),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_cap   (out_tuser),
    .out_last  (out_tlast)
  );

  a_connect_clears_ext: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == imcf_pkg::REQ_CONNECT) |=> ext_r == imcf_pkg::EXT_NONE)
    else $error("extended byte not reset by connect");

  a_ext_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && has_out && frame.long_f |=> ext_r == $past(in_tdata[24:17]))
    else $error("extended byte not stored after load-extended frame");

  a_cap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("read capture flagged on a non-final byte");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy && !stat.at_last |-> !in_tready)
    else $error("request taken while a frame is still being sent");

endmodule

`default_nettype wire
